/* design/tqs_pkg.sv */
`timescale 1ns / 1ps
// tqs_pkg: shared types, constants and helper functions for the tone queue sequencer.
// No dependencies; used by every module of the block.
package tqs_pkg;

    localparam int RING_DEPTH = 8;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_SCALE = 1'd1;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PLAY = 1'b1;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_MAIN  = 2'd1;
    localparam logic [1:0] KIND_VARIO = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [7:0]        freq;
        logic [7:0]        length;
        logic [7:0]        pause;
        logic [3:0]        repeat_count;
        logic              preempt;
        logic              vario;
        logic signed [7:0] freq_step;
    } item_t;

    typedef struct packed {
        logic       sound_on;
        logic [7:0] tone_freq;
        logic       dropped;
        logic       queue_empty;
    } result_t;

    typedef struct packed {
        logic [7:0] pitch_offset;
        logic [3:0] length_scale;
    } cfg_regs_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] freq;
        logic [7:0] length;
        logic [7:0] pause;
        logic [3:0] repeat_count;
        logic       preempt;
        logic [7:0] step;
    } cmd_t;

    typedef struct packed {
        logic [7:0] freq;
        logic [7:0] length;
        logic [7:0] pause;
        logic [3:0] repeat_count;
        logic [7:0] step;
    } ring_entry_t;

    // Reciprocal of (1 - s) in 0.16 fixed point, rounded up; exact floor for 8-bit lengths.
    function automatic logic [15:0] scale_recip(input logic [3:0] s);
        logic [15:0] r;
        unique case (s)
            4'hF:    r = 16'd32768;
            4'hE:    r = 16'd21846;
            4'hD:    r = 16'd16384;
            4'hC:    r = 16'd13108;
            4'hB:    r = 16'd10923;
            4'hA:    r = 16'd9363;
            4'h9:    r = 16'd8192;
            4'h8:    r = 16'd7282;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [RING_AW-1:0] next_ptr(input logic [RING_AW-1:0] p);
        logic [RING_AW-1:0] n;
        if (p == RING_AW'(RING_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + RING_AW'(1);
        end
        return n;
    endfunction

endpackage

/* design/tqs_front.sv */
`timescale 1ns / 1ps
// tqs_front: accepts input items, classifies them, applies pitch offset and length scaling to
// main play items only, and holds all items in a two-entry command queue. Depends on tqs_pkg.
module tqs_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tqs_pkg::item_t    item,
    input  tqs_pkg::cfg_regs_t cfg,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output tqs_pkg::cmd_t     cmd
);

    tqs_pkg::cmd_t q_reg [2];
    logic          rd_reg;
    logic          rd_next;
    logic          wr_reg;
    logic          wr_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;

    logic          push_ok;
    logic          pop_ok;
    logic [15:0]   recip;
    logic [3:0]    mul_factor;
    logic [23:0]   div_prod;
    logic [11:0]   mul_prod;
    logic [7:0]    scaled_len;
    tqs_pkg::cmd_t cmd_in;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_valid && cmd_ready;

    assign recip      = tqs_pkg::scale_recip(cfg.length_scale);
    assign mul_factor = cfg.length_scale + 4'd1;
    assign div_prod   = 24'(item.length) * 24'(recip);
    assign mul_prod   = 12'(item.length) * 12'(mul_factor);

    always_comb
    begin
        priority if (cfg.length_scale[3])
        begin
            scaled_len = div_prod[23:16];
        end
        else if (cfg.length_scale != 4'd0)
        begin
            scaled_len = mul_prod[7:0];
        end
        else
        begin
            scaled_len = item.length;
        end
    end

    always_comb
    begin
        cmd_in.pause        = item.pause;
        cmd_in.repeat_count = item.repeat_count;
        cmd_in.preempt      = item.preempt;
        cmd_in.step         = item.freq_step;
        priority if (item.opcode == tqs_pkg::OP_TICK)
        begin
            cmd_in.kind   = tqs_pkg::KIND_TICK;
            cmd_in.freq   = item.freq;
            cmd_in.length = item.length;
        end
        else if (item.vario)
        begin
            cmd_in.kind   = tqs_pkg::KIND_VARIO;
            cmd_in.freq   = item.freq;
            cmd_in.length = item.length;
        end
        else
        begin
            cmd_in.kind   = tqs_pkg::KIND_MAIN;
            cmd_in.freq   = item.freq + cfg.pitch_offset;
            cmd_in.length = scaled_len;
        end
    end

    always_comb
    begin
        rd_next  = pop_ok ? ~rd_reg : rd_reg;
        wr_next  = push_ok ? ~wr_reg : wr_reg;
        cnt_next = cnt_reg + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_reg] <= cmd_in;
        end
    end

endmodule

/* design/tqs_back.sv */
`timescale 1ns / 1ps
// tqs_back: tone state, ring queue of pending tones and the two-entry result queue.
// Executes one command per cycle while the result queue has room. Depends on tqs_pkg.
module tqs_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  tqs_pkg::cmd_t     cmd,
    output logic              empty,
    input  logic              pop,
    output tqs_pkg::result_t  result
);

    logic [7:0] cur_freq_reg,      cur_freq_next;
    logic [7:0] cur_time_left_reg, cur_time_left_next;
    logic [7:0] cur_pause_reg,     cur_pause_next;
    logic [7:0] cur_step_reg,      cur_step_next;
    logic [7:0] vario_freq_reg,    vario_freq_next;
    logic [7:0] vario_time_reg,    vario_time_next;
    logic [7:0] vario_pause_reg,   vario_pause_next;
    logic [tqs_pkg::RING_AW-1:0] rp_reg, rp_next;
    logic [tqs_pkg::RING_AW-1:0] wp_reg, wp_next;

    tqs_pkg::ring_entry_t ring_reg [tqs_pkg::RING_DEPTH];
    tqs_pkg::ring_entry_t rd_entry;
    tqs_pkg::ring_entry_t ring_wdata;
    logic [tqs_pkg::RING_AW-1:0] ring_waddr;
    logic                        ring_we;

    tqs_pkg::result_t res_q_reg [2];
    logic             res_rd_reg, res_rd_next;
    logic             res_wr_reg, res_wr_next;
    logic [1:0]       res_cnt_reg, res_cnt_next;
    tqs_pkg::result_t res_in;

    logic                        fire;
    logic                        res_pop;
    logic                        start;
    logic [3:0]                  flags;
    logic [tqs_pkg::RING_AW-1:0] base;
    logic [tqs_pkg::RING_AW-1:0] nx;

    assign cmd_ready = (res_cnt_reg != 2'd2);
    assign fire      = cmd_valid && cmd_ready;
    assign empty     = (res_cnt_reg == 2'd0);
    assign result    = res_q_reg[res_rd_reg];
    assign res_pop   = pop && !empty;
    assign rd_entry  = ring_reg[rp_reg];

    assign start = cmd.preempt || ((cur_time_left_reg == 8'd0) && (rp_reg == wp_reg));
    assign flags = start ? cmd.repeat_count : (cmd.repeat_count + 4'd1);
    assign base  = start ? rp_reg : wp_reg;
    assign nx    = tqs_pkg::next_ptr(base);

    always_comb
    begin
        cur_freq_next      = cur_freq_reg;
        cur_time_left_next = cur_time_left_reg;
        cur_pause_next     = cur_pause_reg;
        cur_step_next      = cur_step_reg;
        vario_freq_next    = vario_freq_reg;
        vario_time_next    = vario_time_reg;
        vario_pause_next   = vario_pause_reg;
        rp_next            = rp_reg;
        wp_next            = wp_reg;
        ring_we            = 1'b0;
        ring_waddr         = wp_reg;
        ring_wdata         = rd_entry;
        res_in             = '0;

        if (fire)
        begin
            unique case (cmd.kind)
                tqs_pkg::KIND_VARIO:
                begin
                    vario_freq_next  = cmd.freq;
                    vario_time_next  = cmd.length;
                    vario_pause_next = cmd.pause;
                end
                tqs_pkg::KIND_MAIN:
                begin
                    if (start)
                    begin
                        cur_freq_next      = cmd.freq;
                        cur_time_left_next = cmd.length;
                        cur_pause_next     = cmd.pause;
                        cur_step_next      = cmd.step;
                        wp_next            = rp_reg;
                    end
                    if (flags != 4'd0)
                    begin
                        if (nx != rp_reg)
                        begin
                            ring_we                 = 1'b1;
                            ring_waddr              = base;
                            ring_wdata.freq         = cmd.freq;
                            ring_wdata.length       = cmd.length;
                            ring_wdata.pause        = cmd.pause;
                            ring_wdata.repeat_count = flags - 4'd1;
                            ring_wdata.step         = cmd.step;
                            wp_next                 = nx;
                        end
                        else
                        begin
                            res_in.dropped = 1'b1;
                        end
                    end
                end
                default:
                begin
                    priority if (cur_time_left_reg != 8'd0)
                    begin
                        if (cur_freq_reg != 8'd0)
                        begin
                            res_in.sound_on  = 1'b1;
                            res_in.tone_freq = cur_freq_reg;
                        end
                        cur_time_left_next = cur_time_left_reg - 8'd1;
                        cur_freq_next      = cur_freq_reg + cur_step_reg;
                    end
                    else if (cur_pause_reg != 8'd0)
                    begin
                        cur_pause_next = cur_pause_reg - 8'd1;
                    end
                    else if (rp_reg != wp_reg)
                    begin
                        cur_freq_next      = rd_entry.freq;
                        cur_time_left_next = rd_entry.length;
                        cur_step_next      = rd_entry.step;
                        cur_pause_next     = rd_entry.pause;
                        if (rd_entry.repeat_count == 4'd0)
                        begin
                            rp_next = tqs_pkg::next_ptr(rp_reg);
                        end
                        else
                        begin
                            ring_we                 = 1'b1;
                            ring_waddr              = rp_reg;
                            ring_wdata.repeat_count = rd_entry.repeat_count - 4'd1;
                        end
                    end
                    else if (vario_time_reg != 8'd0)
                    begin
                        if (vario_freq_reg != 8'd0)
                        begin
                            res_in.sound_on  = 1'b1;
                            res_in.tone_freq = vario_freq_reg;
                        end
                        vario_time_next = vario_time_reg - 8'd1;
                    end
                    else if (vario_pause_reg != 8'd0)
                    begin
                        vario_pause_next = vario_pause_reg - 8'd1;
                    end
                end
            endcase
        end

        res_in.queue_empty = (rp_next == wp_next);
    end

    always_comb
    begin
        res_rd_next  = res_pop ? ~res_rd_reg : res_rd_reg;
        res_wr_next  = fire ? ~res_wr_reg : res_wr_reg;
        res_cnt_next = res_cnt_reg + 2'(fire) - 2'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_freq_reg      <= 8'd0;
            cur_time_left_reg <= 8'd0;
            cur_pause_reg     <= 8'd0;
            cur_step_reg      <= 8'd0;
            vario_freq_reg    <= 8'd0;
            vario_time_reg    <= 8'd0;
            vario_pause_reg   <= 8'd0;
            rp_reg            <= '0;
            wp_reg            <= '0;
            res_rd_reg        <= 1'b0;
            res_wr_reg        <= 1'b0;
            res_cnt_reg       <= 2'd0;
        end
        else
        begin
            cur_freq_reg      <= cur_freq_next;
            cur_time_left_reg <= cur_time_left_next;
            cur_pause_reg     <= cur_pause_next;
            cur_step_reg      <= cur_step_next;
            vario_freq_reg    <= vario_freq_next;
            vario_time_reg    <= vario_time_next;
            vario_pause_reg   <= vario_pause_next;
            rp_reg            <= rp_next;
            wp_reg            <= wp_next;
            res_rd_reg        <= res_rd_next;
            res_wr_reg        <= res_wr_next;
            res_cnt_reg       <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_reg[ring_waddr] <= ring_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_q_reg[res_wr_reg] <= res_in;
        end
    end

endmodule

/* design/tone_queue_sequencer.sv */
`timescale 1ns / 1ps
// tone_queue_sequencer: top level; holds the configuration registers and joins
// tqs_front and tqs_back. Depends on tqs_pkg, tqs_front, tqs_back.
//
//  channel   handshake            payload
//  input     push / full          item   (tqs_pkg::item_t)
//  result    empty / pop          result (tqs_pkg::result_t)
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item enters the two-entry command queue at the accepting edge; at its head the
// back end executes it and registers its result into the result queue, from which
// it shows on the result ports. One item per cycle is sustained while pop keeps up.
// Reset clears all control state at once; the ring contents need no clearing.
// A full result queue stalls the back end, which in turn raises full.
module tone_queue_sequencer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  tqs_pkg::item_t                     item,
    output logic                               empty,
    input  logic                               pop,
    output tqs_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tqs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tqs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tqs_pkg::cfg_regs_t cfg_reg;
    tqs_pkg::cfg_regs_t cfg_next;
    logic               cmd_valid;
    logic               cmd_ready;
    tqs_pkg::cmd_t      cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tqs_pkg::CFG_PITCH_OFFSET: cfg_next.pitch_offset = cfg_data[7:0];
                tqs_pkg::CFG_LENGTH_SCALE: cfg_next.length_scale = cfg_data[3:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tqs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tqs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

/* design/tqs_checker.sv */
`timescale 1ns / 1ps
// tqs_checker: port-level assertions for tone_queue_sequencer, bound to the top level.
// Depends on tqs_pkg.
module tqs_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input tqs_pkg::result_t result
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before pop");

    a_sound_has_freq: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.sound_on) |-> (result.tone_freq != 8'd0))
        else $error("speaker on with zero frequency");

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.sound_on) |-> (result.tone_freq == 8'd0))
        else $error("silent transaction carries a frequency");

    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.dropped) |-> !result.sound_on)
        else $error("dropped play reported as sounding");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result present right after reset");

endmodule

bind tone_queue_sequencer tqs_checker u_tqs_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

/* test/tone_queue_sequencer_tb.sv */
`timescale 1ns / 1ps
// tone_queue_sequencer_tb: self-checking bench; a scoreboard class predicts tone, ring and
// vario behavior per transaction; directed then random traffic with random idling.
// Depends on tqs_pkg and tone_queue_sequencer.
module tone_queue_sequencer_tb;

    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 275;
    localparam int SHOWN_ERRORS = 40;

    class tone_scoreboard;
        logic [7:0]                  pitch_offset = '0;
        logic [3:0]                  length_scale = '0;
        logic [7:0]                  cur_freq     = '0;
        logic [7:0]                  cur_left     = '0;
        logic [7:0]                  cur_pause    = '0;
        logic [7:0]                  cur_step     = '0;
        tqs_pkg::ring_entry_t        ring [tqs_pkg::RING_DEPTH];
        logic [tqs_pkg::RING_AW-1:0] rd_ptr       = '0;
        logic [tqs_pkg::RING_AW-1:0] wr_ptr       = '0;
        logic [7:0]                  vario_freq   = '0;
        logic [7:0]                  vario_left   = '0;
        logic [7:0]                  vario_pause  = '0;
        tqs_pkg::result_t            expected_tones [$];
        int                          errors       = 0;

        function int pending();
            return expected_tones.size();
        endfunction

        function logic [tqs_pkg::RING_AW-1:0] step_ptr(logic [tqs_pkg::RING_AW-1:0] p);
            if (int'(p) == tqs_pkg::RING_DEPTH - 1)
            begin
                return '0;
            end
            return p + 1'b1;
        endfunction

        function logic [7:0] scaled_length(logic [7:0] len);
            int s;
            s = int'($signed(length_scale));
            if (s < 0)
            begin
                return 8'(int'(len) / (1 - s));
            end
            if (s > 0)
            begin
                return 8'(int'(len) * (1 + s));
            end
            return len;
        endfunction

        function void note_config(logic [tqs_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == tqs_pkg::CFG_PITCH_OFFSET)
            begin
                pitch_offset = data;
            end
            else if (idx == tqs_pkg::CFG_LENGTH_SCALE)
            begin
                length_scale = data[3:0];
            end
        endfunction

        function void note_item(tqs_pkg::item_t it);
            tqs_pkg::result_t            r;
            logic [7:0]                  f;
            logic [7:0]                  len;
            logic [3:0]                  flags;
            logic [tqs_pkg::RING_AW-1:0] nx;
            r = '0;
            if (it.opcode == tqs_pkg::OP_PLAY)
            begin
                if (it.vario)
                begin
                    vario_freq  = it.freq;
                    vario_left  = it.length;
                    vario_pause = it.pause;
                end
                else
                begin
                    f     = it.freq + pitch_offset;
                    len   = scaled_length(it.length);
                    flags = it.repeat_count;
                    if (it.preempt || (cur_left == 0 && rd_ptr == wr_ptr))
                    begin
                        cur_freq  = f;
                        cur_left  = len;
                        cur_pause = it.pause;
                        cur_step  = it.freq_step;
                        wr_ptr    = rd_ptr;
                    end
                    else
                    begin
                        flags = flags + 4'd1;
                    end
                    if (flags != 0)
                    begin
                        nx = step_ptr(wr_ptr);
                        if (nx != rd_ptr)
                        begin
                            ring[wr_ptr].freq         = f;
                            ring[wr_ptr].length       = len;
                            ring[wr_ptr].pause        = it.pause;
                            ring[wr_ptr].repeat_count = flags - 4'd1;
                            ring[wr_ptr].step         = it.freq_step;
                            wr_ptr = nx;
                        end
                        else
                        begin
                            r.dropped = 1'b1;
                        end
                    end
                end
            end
            else if (cur_left != 0)
            begin
                if (cur_freq != 0)
                begin
                    r.sound_on  = 1'b1;
                    r.tone_freq = cur_freq;
                end
                cur_left = cur_left - 8'd1;
                cur_freq = cur_freq + cur_step;
            end
            else if (cur_pause != 0)
            begin
                cur_pause = cur_pause - 8'd1;
            end
            else if (rd_ptr != wr_ptr)
            begin
                cur_freq  = ring[rd_ptr].freq;
                cur_left  = ring[rd_ptr].length;
                cur_step  = ring[rd_ptr].step;
                cur_pause = ring[rd_ptr].pause;
                if (ring[rd_ptr].repeat_count == 0)
                begin
                    rd_ptr = step_ptr(rd_ptr);
                end
                else
                begin
                    ring[rd_ptr].repeat_count = ring[rd_ptr].repeat_count - 4'd1;
                end
            end
            else if (vario_left != 0)
            begin
                if (vario_freq != 0)
                begin
                    r.sound_on  = 1'b1;
                    r.tone_freq = vario_freq;
                end
                vario_left = vario_left - 8'd1;
            end
            else if (vario_pause != 0)
            begin
                vario_pause = vario_pause - 8'd1;
            end
            r.queue_empty = (rd_ptr == wr_ptr);
            expected_tones.push_back(r);
        endfunction

        function void flag_mismatch(string what, int want, int got);
            errors++;
            if (errors <= SHOWN_ERRORS)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(tqs_pkg::result_t got);
            tqs_pkg::result_t want;
            if (expected_tones.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual %p", $time, got);
                return;
            end
            want = expected_tones.pop_front();
            if (got.sound_on !== want.sound_on)
            begin
                flag_mismatch("sound_on", want.sound_on, got.sound_on);
            end
            if (got.tone_freq !== want.tone_freq)
            begin
                flag_mismatch("tone_freq", want.tone_freq, got.tone_freq);
            end
            if (got.dropped !== want.dropped)
            begin
                flag_mismatch("dropped", want.dropped, got.dropped);
            end
            if (got.queue_empty !== want.queue_empty)
            begin
                flag_mismatch("queue_empty", want.queue_empty, got.queue_empty);
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           push;
    logic                           full;
    tqs_pkg::item_t                 item;
    logic                           empty;
    logic                           pop;
    tqs_pkg::result_t               result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tqs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tqs_pkg::CFG_DATA_W-1:0] cfg_data;

    tone_scoreboard sb = new;
    bit             quiet    = 1'b0;
    bit             hold_off = 1'b0;

    tone_queue_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic tqs_pkg::item_t mk_play(logic [7:0] f, logic [7:0] len,
                                               logic [7:0] pau, logic [3:0] rep,
                                               logic now, logic var_tone,
                                               logic [7:0] step);
        tqs_pkg::item_t it;
        it.opcode       = tqs_pkg::OP_PLAY;
        it.freq         = f;
        it.length       = len;
        it.pause        = pau;
        it.repeat_count = rep;
        it.preempt      = now;
        it.vario        = var_tone;
        it.freq_step    = step;
        return it;
    endfunction

    function automatic tqs_pkg::item_t rand_tick();
        tqs_pkg::item_t it;
        it = mk_play(8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                     1'($urandom), 1'($urandom), 8'($urandom));
        it.opcode = tqs_pkg::OP_TICK;
        return it;
    endfunction

    function automatic tqs_pkg::item_t rand_play(bit queued);
        logic [7:0] len;
        logic [7:0] pau;
        logic [3:0] rep;
        len = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        pau = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        rep = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        return mk_play(8'($urandom), len, pau, rep,
                       !queued && ($urandom_range(0, 4) == 0),
                       $urandom_range(0, 9) == 0, 8'($urandom));
    endfunction

    // Offer one transaction, wait for it to be taken, then idle a random while.
    task automatic send_item(input tqs_pkg::item_t it);
        int n;
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        sb.note_item(it);
        n = gap_len();
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] offset, input logic [3:0] scale);
        logic [7:0] scale_data;
        scale_data = {4'($urandom), scale};
        cfg_valid <= 1'b1;
        cfg_index <= tqs_pkg::CFG_PITCH_OFFSET;
        cfg_data  <= offset;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.note_config(tqs_pkg::CFG_PITCH_OFFSET, offset);
        cfg_index <= tqs_pkg::CFG_LENGTH_SCALE;
        cfg_data  <= scale_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.note_config(tqs_pkg::CFG_LENGTH_SCALE, scale_data);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(2, 8);
                repeat (burst) send_item(rand_play(1'b1));
                sent += burst;
            end
            else
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    send_item(rand_play(1'b0));
                end
                else
                begin
                    send_item(rand_tick());
                end
                sent++;
            end
        end
    endtask

    initial
    begin : result_side
        int stall;
        stall = 0;
        pop   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                sb.check_result(result);
                stall = gap_len();
            end
            if (hold_off)
            begin
                hold_off = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_config(8'h00, 4'h0);

        send_item(rand_tick());
        send_item(mk_play(8'd200, 8'd2, 8'd1, 4'd0, 1'b0, 1'b1, 8'h00));
        repeat (3) send_item(rand_tick());
        // silent zero-frequency tone, then the sweep makes it audible
        send_item(mk_play(8'd0, 8'd2, 8'd1, 4'd0, 1'b0, 1'b0, 8'd5));
        repeat (2) send_item(rand_tick());
        send_item(mk_play(8'hFF, 8'hFF, 8'hFF, 4'd0, 1'b1, 1'b0, 8'h80));
        send_item(mk_play(8'd10, 8'd1, 8'd0, 4'd15, 1'b0, 1'b0, 8'h7F));
        // fill the ring; the last one is dropped
        for (int i = 0; i < tqs_pkg::RING_DEPTH; i++)
        begin
            send_item(mk_play(8'(i + 1), 8'(i % 2), 8'd0, 4'd0, 1'b0, 1'b0, 8'h7F));
        end
        send_item(rand_tick());
        send_item(mk_play(8'd30, 8'd1, 8'd0, 4'd2, 1'b1, 1'b0, 8'h00));
        repeat (6) send_item(rand_tick());
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       load_config(8'hFF, 4'h8);
                1:       load_config(8'h00, 4'h7);
                2:       load_config(8'h80, 4'hC);
                3:       load_config(8'h01, 4'h4);
                default: load_config(8'($urandom), 4'($urandom));
            endcase
            quiet = (ph == 1);
            if (ph == 2)
            begin
                hold_off = 1'b1;
            end
            run_random(PHASE_ITEMS);
            settle();
        end

        quiet = 1'b0;
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("%0t: timeout, %0d transactions outstanding", $time, sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
